>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the decoder engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition in one cycle requires a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/irpfd_pkg.sv
// ----------------------------------------------------------------------------
// irpfd_pkg
// Types, constants and helper functions of the 48-bit IR frame decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

   // Reference durations in microseconds.
   localparam logic [11:0] HdrMark   = 12'd3502;
   localparam logic [11:0] HdrSpace  = 12'd1750;
   localparam logic [11:0] BitMark   = 12'd502;
   localparam logic [11:0] ZeroSpace = 12'd400;
   localparam logic [11:0] OneSpace  = 12'd1244;

   localparam logic [5:0] TotalBits = 6'd48;

   localparam logic [6:0] Percent      = 7'd100;
   localparam logic [6:0] TolReset     = 7'd25;
   // floor(x / 100) as (x * Div100Mult) >> Div100Shift, exact for x below 2^20.
   localparam int          Div100Shift = 27;
   localparam logic [20:0] Div100Mult  = 21'd1342178;

   localparam logic [1:0] StatusOk     = 2'd0;
   localparam logic [1:0] StatusHeader = 2'd1;
   localparam logic [1:0] StatusBit    = 2'd2;

   localparam logic [1:0] CsrTolerance = 2'd0;
   localparam logic [1:0] CsrAddress   = 2'd1;
   localparam logic [1:0] CsrCommand   = 2'd2;

   typedef struct packed {
      logic        frame_start;
      logic [15:0] mark_us;
      logic [15:0] space_us;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  failed_pair;
      logic [15:0] decoded_address;
      logic [31:0] decoded_command;
      logic        is_match;
   } rsp_item_type;

   typedef struct packed {
      logic [13:0] lo;
      logic [13:0] hi;
   } window_type;

   typedef struct packed {
      window_type hdr_mark;
      window_type hdr_space;
      window_type bit_mark;
      window_type one_space;
      window_type zero_space;
   } bounds_type;

   typedef struct packed {
      logic hdr_ok;
      logic bit_one;
      logic bit_zero;
   } pair_flags_type;

   function automatic logic [13:0] div100(input logic [19:0] x);
      logic [40:0] prod;
      prod = {21'd0, x} * {20'd0, Div100Mult};
      return prod[Div100Shift +: 14];
   endfunction

   // Acceptance window of a reference for a tolerance, clamped to 100 percent.
   function automatic window_type window(input logic [6:0] tol, input logic [11:0] ref_us);
      logic [6:0]  t;
      logic [19:0] lo_prod;
      logic [19:0] hi_prod;
      window_type  w;
      t = (tol > Percent) ? Percent : tol;
      lo_prod = {13'd0, 7'(Percent - t)} * {8'd0, ref_us};
      hi_prod = 20'({13'd0, Percent} + {13'd0, t}) * {8'd0, ref_us};
      w.lo = div100(lo_prod);
      w.hi = div100(hi_prod);
      return w;
   endfunction

   function automatic logic in_window(input logic [15:0] d, input window_type w);
      return (d >= {2'd0, w.lo}) && (d <= {2'd0, w.hi});
   endfunction

endpackage

>>> design/ir_pulse_frame_decoder_48bit.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_48bit
// Decoder for 48-bit Kaseikyo infrared frames from measured mark/space words.
// ----------------------------------------------------------------------------
// The decoder takes one mark/space word per clock cycle while its input is not
// refused. A word is held in an input register, classified against the
// tolerance windows and folded into the frame state in one pass, and any
// result is then registered in the output register. Input is refused only
// while a finished result waits to be taken. The tolerance windows are worked
// out when the tolerance register is written; configuration writes complete
// in the cycle they are presented.
module ir_pulse_frame_decoder_48bit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  irpfd_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output irpfd_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata
);
   import irpfd_pkg::*;

   bounds_type     bounds;
   logic [15:0]    expected_address;
   logic [31:0]    expected_command;
   req_item_type   stage_item;
   pair_flags_type flags;

   irpfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .bounds           (bounds),
      .expected_address (expected_address),
      .expected_command (expected_command)
   );

   irpfd_classifier u_classifier (
      .bounds (bounds),
      .item   (stage_item),
      .flags  (flags)
   );

   irpfd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .stage_item       (stage_item),
      .flags            (flags),
      .expected_address (expected_address),
      .expected_command (expected_command),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

>>> design/irpfd_csr.sv
// ----------------------------------------------------------------------------
// irpfd_csr
// Configuration registers; the tolerance is kept as precomputed windows.
// ----------------------------------------------------------------------------
module irpfd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output irpfd_pkg::bounds_type bounds,
   output logic [15:0]           expected_address,
   output logic [31:0]           expected_command
);
   import irpfd_pkg::*;

   bounds_type  bounds_ff;
   bounds_type  bounds_in;
   logic [15:0] address_ff;
   logic [31:0] command_ff;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      bounds_in.hdr_mark   = window(csr_wdata[6:0], HdrMark);
      bounds_in.hdr_space  = window(csr_wdata[6:0], HdrSpace);
      bounds_in.bit_mark   = window(csr_wdata[6:0], BitMark);
      bounds_in.one_space  = window(csr_wdata[6:0], OneSpace);
      bounds_in.zero_space = window(csr_wdata[6:0], ZeroSpace);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.hdr_mark   <= window(TolReset, HdrMark);
         bounds_ff.hdr_space  <= window(TolReset, HdrSpace);
         bounds_ff.bit_mark   <= window(TolReset, BitMark);
         bounds_ff.one_space  <= window(TolReset, OneSpace);
         bounds_ff.zero_space <= window(TolReset, ZeroSpace);
         address_ff           <= '0;
         command_ff           <= '0;
      end else if (write) begin
         unique case (csr_index)
            CsrTolerance: bounds_ff  <= bounds_in;
            CsrAddress:   address_ff <= csr_wdata[15:0];
            CsrCommand:   command_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bounds           = bounds_ff;
   assign expected_address = address_ff;
   assign expected_command = command_ff;

endmodule

>>> design/irpfd_classifier.sv
// ----------------------------------------------------------------------------
// irpfd_classifier
// Window compares that classify one mark/space pair.
// ----------------------------------------------------------------------------
module irpfd_classifier (
   input  irpfd_pkg::bounds_type     bounds,
   input  irpfd_pkg::req_item_type   item,
   output irpfd_pkg::pair_flags_type flags
);
   import irpfd_pkg::*;

   logic mark_ok;

   assign mark_ok = in_window(item.mark_us, bounds.bit_mark);

   always_comb begin
      flags.hdr_ok   = in_window(item.mark_us, bounds.hdr_mark) &&
                       in_window(item.space_us, bounds.hdr_space);
      // Both flags can be set where the two windows overlap; the engine lets a one win.
      flags.bit_one  = mark_ok && in_window(item.space_us, bounds.one_space);
      flags.bit_zero = mark_ok && in_window(item.space_us, bounds.zero_space);
   end

endmodule

>>> design/irpfd_engine.sv
// ----------------------------------------------------------------------------
// irpfd_engine
// Input stage, frame state and result register of the decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irpfd_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  irpfd_pkg::req_item_type   req_data,
   output irpfd_pkg::req_item_type   stage_item,
   input  irpfd_pkg::pair_flags_type flags,
   input  logic [15:0]               expected_address,
   input  logic [31:0]               expected_command,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output irpfd_pkg::rsp_item_type   rsp_data
);
   import irpfd_pkg::*;

   logic         stage_valid_ff;
   logic         stage_valid_in;
   req_item_type stage_item_ff;
   logic         advance;
   logic         accept;

   logic         active_ff;
   logic         active_in;
   logic [5:0]   idx_ff;
   logic [5:0]   idx_in;
   logic [47:0]  shift_ff;
   logic [47:0]  shift_in;

   logic         emit;
   rsp_item_type result;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_data_ff;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign stage_valid_in = accept || (stage_valid_ff && !advance);
   assign stage_item     = stage_item_ff;

   always_comb begin
      logic        act;
      logic [5:0]  idx;
      logic [47:0] shift;
      logic [47:0] shift_new;
      logic [5:0]  pos;
      active_in = active_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      emit      = 1'b0;
      result    = '0;
      act       = stage_item_ff.frame_start || active_ff;
      idx       = stage_item_ff.frame_start ? '0 : idx_ff;
      shift     = stage_item_ff.frame_start ? '0 : shift_ff;
      pos       = 6'(TotalBits - idx);
      shift_new = flags.bit_one ? (shift | (48'd1 << pos)) : shift;
      if (advance) begin
         active_in = act;
         idx_in    = idx;
         shift_in  = shift;
         if (act) begin
            if (idx == '0) begin
               if (flags.hdr_ok) begin
                  idx_in = 6'd1;
               end else begin
                  emit          = 1'b1;
                  result.status = StatusHeader;
                  active_in     = 1'b0;
               end
            end else if (flags.bit_one || flags.bit_zero) begin
               shift_in = shift_new;
               if (idx == TotalBits) begin
                  emit                   = 1'b1;
                  result.status          = StatusOk;
                  result.decoded_address = shift_new[47:32];
                  result.decoded_command = shift_new[31:0];
                  result.is_match        = (shift_new[47:32] == expected_address) &&
                                           (shift_new[31:0] == expected_command);
                  active_in              = 1'b0;
                  idx_in                 = '0;
               end else begin
                  idx_in = idx + 6'd1;
               end
            end else begin
               emit                   = 1'b1;
               result.status          = StatusBit;
               result.failed_pair     = idx;
               result.decoded_address = shift[47:32];
               result.decoded_command = shift[31:0];
               active_in              = 1'b0;
            end
         end
      end
   end

   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         active_ff      <= 1'b0;
         idx_ff         <= '0;
         shift_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         active_ff      <= active_in;
         idx_ff         <= idx_in;
         shift_ff       <= shift_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (accept) begin
         stage_item_ff <= req_data;
      end
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An open frame always sits between the header and the last bit.
   `ASSERT_ALWAYS(a_active_index, clock, reset,
                  active_ff |-> (idx_ff >= 6'd1 && idx_ff <= TotalBits))
   `ASSERT_NEXT(a_emit_closes, clock, reset, advance && emit, !active_ff)
   `ASSERT_ALWAYS(a_match_only_ok, clock, reset,
                  (rsp_valid_ff && rsp_data_ff.is_match) |-> (rsp_data_ff.status == StatusOk))
   `ASSERT_ALWAYS(a_header_fields, clock, reset,
                  (rsp_valid_ff && rsp_data_ff.status == StatusHeader) |->
                  (rsp_data_ff.decoded_address == '0 && rsp_data_ff.decoded_command == '0 &&
                   rsp_data_ff.failed_pair == '0))

endmodule

>>> dv/irpfd_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpfd_frame_checker
// Watches the word, result and register channels of the IR frame decoder.
// It keeps its own copy of the frame state and the register settings. From
// each accepted mark/space word it predicts the frame reports. Each accepted
// report is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module irpfd_frame_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  irpfd_pkg::req_item_type req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  irpfd_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   output int                      failures,
   output int                      outstanding
);
   import irpfd_pkg::*;

   logic [6:0]   tol_pct;
   logic [15:0]  want_address;
   logic [31:0]  want_command;
   int unsigned  pair_pos;
   logic [47:0]  bits_seen;
   bit           in_frame;
   rsp_item_type frame_reports[$];
   int           mismatches = 0;

   // A duration passes when it lies inside the floored percentage window.
   function automatic bit near(input logic [15:0] d, input int unsigned ref_us);
      int unsigned t;
      int unsigned lo;
      int unsigned hi;
      t = (tol_pct > 7'd100) ? 100 : tol_pct;
      lo = ((100 - t) * ref_us) / 100;
      hi = ((100 + t) * ref_us) / 100;
      return (d >= lo) && (d <= hi);
   endfunction

   function automatic rsp_item_type frame_report(input logic [1:0] status,
                                                 input int unsigned pair);
      rsp_item_type r;
      r.status          = status;
      r.failed_pair     = 6'(pair);
      r.decoded_address = bits_seen[47:32];
      r.decoded_command = bits_seen[31:0];
      r.is_match        = (status == StatusOk) && (bits_seen[47:32] == want_address) &&
                          (bits_seen[31:0] == want_command);
      return r;
   endfunction

   task automatic decode_pair(input req_item_type w);
      bit mark_ok;
      if (w.frame_start) begin
         pair_pos  = 0;
         bits_seen = '0;
         in_frame  = 1'b1;
      end
      if (!in_frame) return;

      if (pair_pos == 0) begin
         if (near(w.mark_us, HdrMark) && near(w.space_us, HdrSpace)) begin
            pair_pos = 1;
         end else begin
            bits_seen = '0;
            frame_reports.push_back(frame_report(StatusHeader, 0));
            in_frame = 1'b0;
         end
         return;
      end

      // The one space is tried before the zero space, which matters once
      // the windows overlap at wide tolerances.
      mark_ok = near(w.mark_us, BitMark);
      if (mark_ok && near(w.space_us, OneSpace)) begin
         bits_seen[int'(TotalBits) - pair_pos] = 1'b1;
      end else if (!(mark_ok && near(w.space_us, ZeroSpace))) begin
         frame_reports.push_back(frame_report(StatusBit, pair_pos));
         in_frame = 1'b0;
         return;
      end

      if (pair_pos >= int'(TotalBits)) begin
         frame_reports.push_back(frame_report(StatusOk, 0));
         in_frame = 1'b0;
         pair_pos = 0;
      end else begin
         pair_pos++;
      end
   endtask

   task automatic check_report(input rsp_item_type got);
      rsp_item_type want;
      if (frame_reports.size() == 0) begin
         $error("frame report with none expected: status %0d, pair %0d",
                got.status, got.failed_pair);
         mismatches++;
         return;
      end
      want = frame_reports.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         mismatches++;
      end
      if (got.failed_pair !== want.failed_pair) begin
         $error("failed_pair: expected %0d, got %0d", want.failed_pair, got.failed_pair);
         mismatches++;
      end
      if (got.decoded_address !== want.decoded_address) begin
         $error("decoded_address: expected %h, got %h",
                want.decoded_address, got.decoded_address);
         mismatches++;
      end
      if (got.decoded_command !== want.decoded_command) begin
         $error("decoded_command: expected %h, got %h",
                want.decoded_command, got.decoded_command);
         mismatches++;
      end
      if (got.is_match !== want.is_match) begin
         $error("is_match: expected %0d, got %0d", want.is_match, got.is_match);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tol_pct      = TolReset;
         want_address = '0;
         want_command = '0;
         pair_pos     = 0;
         bits_seen    = '0;
         in_frame     = 1'b0;
         frame_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrTolerance: tol_pct = csr_wdata[6:0];
               CsrAddress:   want_address = csr_wdata[15:0];
               CsrCommand:   want_command = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) decode_pair(req_data);
         if (rsp_valid && rsp_ready) check_report(rsp_data);
      end
      failures    <= mismatches;
      outstanding <= frame_reports.size();
   end

endmodule

>>> dv/ir_pulse_frame_decoder_48bit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_48bit_tb
// Drives mark/space words into the 48-bit IR frame decoder: a short directed
// opening, then mostly well-formed frames with jittered timing, mixed with
// broken frames, abandoned frames and noise, across several tolerance and
// match settings. Both channels idle at random; once the result side holds
// off for a long stretch. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_48bit_tb;
   import irpfd_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   int           report_failures;
   int           report_backlog;

   logic [6:0]   cur_tol = TolReset;
   int unsigned  words_sent = 0;
   int unsigned  req_calm = 0;

   ir_pulse_frame_decoder_48bit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   irpfd_frame_checker frame_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (report_failures),
      .outstanding (report_backlog)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // A duration somewhere inside the current window, bounds included.
   function automatic logic [15:0] jitter(input int unsigned ref_us);
      int unsigned t;
      t = (cur_tol > 7'd100) ? 100 : cur_tol;
      return 16'(((100 - t + $urandom_range(0, 2 * t)) * ref_us) / 100);
   endfunction

   function automatic logic [15:0] outside_of(input int unsigned ref_us);
      int unsigned t;
      int unsigned lo;
      int unsigned hi;
      t = (cur_tol > 7'd100) ? 100 : cur_tol;
      lo = ((100 - t) * ref_us) / 100;
      hi = ((100 + t) * ref_us) / 100;
      case ($urandom_range(0, 2))
         0: return 16'(hi + 1 + $urandom_range(0, 50));
         1: return (lo > 0) ? 16'(lo - 1) : 16'(hi + 1);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_pair(input bit start, input logic [15:0] mark,
                            input logic [15:0] space);
      int unsigned  gap;
      req_item_type w;
      if (req_calm > 0) begin
         gap = 0;
         req_calm--;
      end else begin
         gap = $urandom_range(0, 19);
         if ($urandom_range(0, 40) == 0) req_calm = $urandom_range(20, 80);
      end
      w.frame_start = start;
      w.mark_us     = mark;
      w.space_us    = space;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Sends a frame up to pair cut_at. That pair is sent broken when corrupt
   // is set and left out otherwise, so a frame cut short is abandoned.
   task automatic send_frame(input logic [47:0] payload, input int cut_at, input bit corrupt);
      int          i;
      logic [15:0] mark;
      logic [15:0] space;
      for (i = 0; i <= int'(TotalBits); i++) begin
         if (i == cut_at && !corrupt) return;
         if (i == 0) begin
            mark  = jitter(HdrMark);
            space = jitter(HdrSpace);
         end else begin
            mark  = jitter(BitMark);
            space = payload[int'(TotalBits) - i] ? jitter(OneSpace) : jitter(ZeroSpace);
         end
         if (i == cut_at) begin
            if ($urandom_range(0, 1)) mark = outside_of((i == 0) ? HdrMark : BitMark);
            else space = outside_of((i == 0) ? HdrSpace : OneSpace);
         end
         send_pair(i == 0, mark, space);
         words_sent++;
         if (i == cut_at) return;
      end
   endtask

   task automatic program_decoder(input logic [6:0] tol, input logic [15:0] addr,
                                  input logic [31:0] cmd);
      int i;
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         case (i)
            0: begin
               csr_index <= CsrTolerance;
               csr_wdata <= {25'd0, tol};
            end
            1: begin
               csr_index <= CsrAddress;
               csr_wdata <= {16'd0, addr};
            end
            default: begin
               csr_index <= CsrCommand;
               csr_wdata <= cmd;
            end
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_tol = tol;
   endtask

   // Words that complete no frame can still be in flight when the last
   // report has come, so the task waits on past an empty backlog before any register write.
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (report_backlog != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      int          phase;
      int          waited;
      logic [6:0]  tol;
      logic [15:0] addr;
      logic [31:0] cmd;
      logic [47:0] payload;
      int unsigned phase_target;
      int unsigned pick;
      bit          start;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CsrTolerance;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset settings.
      send_pair(1'b0, 16'd0, 16'd0);
      send_pair(1'b0, 16'hFFFF, 16'hFFFF);
      send_pair(1'b1, 16'd0, 16'd0);
      send_pair(1'b1, 16'hFFFF, 16'hFFFF);
      send_pair(1'b1, 16'(HdrMark), 16'd0);
      send_pair(1'b1, 16'(HdrMark), 16'(HdrSpace));
      send_pair(1'b0, 16'hFFFF, 16'(OneSpace));
      send_pair(1'b1, 16'(HdrMark), 16'(HdrSpace));
      send_pair(1'b0, 16'(BitMark), 16'(OneSpace));
      send_pair(1'b0, 16'(BitMark), 16'(ZeroSpace));
      // Restart in the middle of a frame, at the window edges, then a space
      // that falls between the zero and one windows.
      send_pair(1'b1, 16'd4377, 16'd2187);
      send_pair(1'b0, 16'd376, 16'd1555);
      send_pair(1'b0, 16'd627, 16'd300);
      send_pair(1'b0, 16'(BitMark), 16'd700);
      send_pair(1'b0, 16'(BitMark), 16'(OneSpace));
      words_sent = 15;

      for (phase = 0; phase < 6; phase++) begin
         addr = 16'($urandom_range(0, 65535));
         cmd  = $urandom;
         case (phase)
            0: begin
               tol  = TolReset;
               addr = 16'hFFFF;
               cmd  = 32'hFFFF_FFFF;
            end
            1: begin
               tol  = 7'd0;
               addr = '0;
               cmd  = '0;
            end
            2: tol = 7'd100;
            3: tol = 7'd127;
            4: tol = 7'($urandom_range(1, 99));
            default: tol = 7'($urandom_range(0, 127));
         endcase
         settle();
         program_decoder(tol, addr, cmd);

         phase_target = words_sent + 240;
         while (words_sent < phase_target) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
               0: payload = {16'($urandom_range(0, 65535)), 32'($urandom)};
               1: payload = '1;
               2: payload = '0;
               default: payload = {addr, cmd};
            endcase
            if (pick < 60) begin
               send_frame(payload, int'(TotalBits) + 1, 1'b0);
            end else if (pick < 80) begin
               send_frame(payload, $urandom_range(0, 48), 1'b1);
               repeat ($urandom_range(0, 3)) send_pair(1'b0, jitter(BitMark), jitter(OneSpace));
            end else if (pick < 88) begin
               send_frame(payload, $urandom_range(1, 48), 1'b0);
            end else begin
               start = 1'($urandom_range(0, 1));
               send_pair(start, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
               if (start) words_sent++;
            end
         end
      end

      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      for (waited = 0; report_backlog != 0 && waited < 5000; waited++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (report_failures == 0 && report_backlog == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : report_drain
      int unsigned hold;
      int unsigned taken;
      int unsigned calm_left;
      taken     = 0;
      calm_left = 0;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (calm_left > 0) begin
            hold = 0;
            calm_left--;
         end else begin
            hold = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
         end
         // One long hold-off so that a waiting report backs up the word side.
         if (taken == 6) hold = 600;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         taken++;
      end
   end

   initial begin : watchdog
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/irpfd_pkg.sv
design/irpfd_csr.sv
design/irpfd_classifier.sv
design/irpfd_engine.sv
design/ir_pulse_frame_decoder_48bit.sv
dv/irpfd_frame_checker.sv
dv/ir_pulse_frame_decoder_48bit_tb.sv
